// ===== hdl/prrw_pkg.sv =====
// Package for the PRR recovery window engine: payload structs, event codes,
// classified item kinds, back-end states and reset values of the config registers.
// No dependencies.
`default_nettype none
package prrw_pkg;

  localparam int unsigned SegW     = 16;
  localparam int unsigned WordW    = 32;
  localparam int unsigned QueueDep = 2;
  localparam logic [SegW-1:0] SegSizeRst = 16'd1460;
  localparam logic            PrrEnRst   = 1'b1;

  localparam logic REG_SEG_SIZE  = 1'b0;
  localparam logic REG_PRR_EN    = 1'b1;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_SENT  = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    K_NOP,
    K_RESET,
    K_BEGIN,
    K_SENT,
    K_ACK
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BEGIN_DIV,
    S_SENT_DIV,
    S_ACK_NEW,
    S_ACK_FLT,
    S_ACK_SST,
    S_ACK_MUL,
    S_ACK_TSTART,
    S_ACK_TGT,
    S_ACK_WIN,
    S_ACK_SUM
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [WordW-1:0] byte_count;
    logic             una_advanced;
    logic             any_newly_lost;
    logic [WordW-1:0] pipe_bytes;
    logic [WordW-1:0] slow_start_threshold;
    logic [WordW-1:0] cwnd_in;
    logic             in_loss_recovery;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] cwnd_out;
    logic             cwnd_written;
    logic             recovery_active;
  } out_item_t;

  // classified word handed from front to back
  typedef struct packed {
    kind_e            kind;
    logic [WordW-1:0] amount;  // cwnd_in for begin, byte_count otherwise
    logic             una;
    logic             lost;
    logic [WordW-1:0] pipe;
    logic [WordW-1:0] ssth;
  } work_t;

endpackage
`default_nettype wire

// ===== hdl/prr_recovery_window_top.sv =====
// Top level of the PRR recovery window engine: config registers, front queue, back end.
// Depends on prrw_pkg, prrw_front, prrw_back.
//
//  channel   direction  handshake          payload
//  input     in         push_i / full_o    in_item_i  (in_item_t)
//  result    out        pop_i / empty_o    out_item_o (out_item_t)
//  config    in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// Reset and ignored events finish from idle; begin, counted data sent and an ack that
// delivers no packet take one divider run; an ack takes three on the slow-start path and
// four on the proportional path, all on the 1-bit-per-cycle shared divider.
// rst_ni clears the episode state and restores the config defaults.
// A two-word queue keeps taking events, until it is full, while the back end works or its result waits.
`default_nettype none
module prr_recovery_window_top import prrw_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire in_item_t        in_item_i,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output out_item_t            out_item_o,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [SegW-1:0] cfg_wdata_i
);

  logic [SegW-1:0] seg_q;
  logic            en_q;
  logic            work_valid, work_take;
  work_t           work;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SegSizeRst;
      en_q  <= PrrEnRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SEG_SIZE) seg_q <= cfg_wdata_i;
      else                           en_q  <= cfg_wdata_i[0];
    end
  end

  prrw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seg_size_i   (seg_q),
    .prr_en_i     (en_q),
    .push_i       (push_i),
    .full_o       (full_o),
    .in_item_i    (in_item_i),
    .work_valid_o (work_valid),
    .work_take_i  (work_take),
    .work_o       (work)
  );

  prrw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seg_size_i   (seg_q),
    .work_valid_i (work_valid),
    .work_take_o  (work_take),
    .work_i       (work),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_item_o   (out_item_o)
  );

endmodule
`default_nettype wire

// ===== hdl/prrw_front.sv =====
// Front end: classifies incoming events against the config and queues them.
// Depends on prrw_pkg.
`default_nettype none
module prrw_front import prrw_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [SegW-1:0] seg_size_i,
  input  wire logic            prr_en_i,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire in_item_t        in_item_i,
  output logic                 work_valid_o,
  input  wire logic            work_take_i,
  output work_t                work_o
);

  work_t       mem_q [QueueDep];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  work_t       cls;
  logic        do_push, do_pop;

  always_comb begin
    cls.amount = in_item_i.byte_count;
    cls.una    = in_item_i.una_advanced;
    cls.lost   = in_item_i.any_newly_lost;
    cls.pipe   = in_item_i.pipe_bytes;
    cls.ssth   = in_item_i.slow_start_threshold;
    cls.kind   = K_NOP;
    unique case (in_item_i.cmd)
      CMD_RESET: cls.kind = K_RESET;
      CMD_BEGIN: begin
        cls.amount = in_item_i.cwnd_in;
        if (prr_en_i && seg_size_i != '0) cls.kind = K_BEGIN;
      end
      // zero segment size counts zero packets, so the word changes nothing
      CMD_SENT: begin
        if (prr_en_i && in_item_i.in_loss_recovery && seg_size_i != '0) cls.kind = K_SENT;
      end
      CMD_ACK: begin
        if (prr_en_i && in_item_i.in_loss_recovery && seg_size_i != '0) cls.kind = K_ACK;
      end
      default: cls.kind = K_NOP;
    endcase
  end

  assign full_o       = (cnt_q == 2'(QueueDep));
  assign work_valid_o = (cnt_q != '0);
  assign work_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = work_take_i && work_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/prrw_div.sv =====
// Radix-2 restoring divider, 64- or 32-bit dividend over a 32-bit divisor,
// one quotient bit per cycle. Depends on prrw_pkg.
`default_nettype none
module prrw_div import prrw_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               wide_i,
  input  wire logic [2*WordW-1:0] dividend_i,
  input  wire logic [WordW-1:0]   divisor_i,
  output logic                    done_o,
  output logic [2*WordW-1:0]      quot_o,
  output logic [WordW-1:0]        rem_o
);

  logic [2*WordW-1:0] dq_q;
  logic [WordW-1:0]   rem_q, dvs_q;
  logic [6:0]         cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [WordW:0]     sh, diff;

  assign sh     = {rem_q, dq_q[2*WordW-1]};
  assign diff   = sh - {1'b0, dvs_q};
  assign quot_o = dq_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= wide_i ? 7'd64 : 7'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // narrow runs take the low word from the top so the quotient lands low
      dq_q  <= wide_i ? dividend_i : {dividend_i[WordW-1:0], {WordW{1'b0}}};
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[WordW]) begin
        rem_q <= diff[WordW-1:0];
        dq_q  <= {dq_q[2*WordW-2:0], 1'b1};
      end else begin
        rem_q <= sh[WordW-1:0];
        dq_q  <= {dq_q[2*WordW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/prrw_back.sv =====
// Back end: sequences begin, sent and ack events through the shared divider and, for acks,
// two multipliers, keeps the episode state and holds one result word. Depends on prrw_pkg, prrw_div.
`default_nettype none
module prrw_back import prrw_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [SegW-1:0] seg_size_i,
  input  wire logic            work_valid_i,
  output logic                 work_take_o,
  input  wire work_t           work_i,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output out_item_t            out_item_o
);

  localparam int unsigned W = WordW;

  state_e             state_q, state_d;
  work_t              item_q, item_d;
  logic               active_q, active_d;
  logic [W-1:0]       deliv_q, deliv_d, sent_q, sent_d, prior_q, prior_d;
  logic [W-1:0]       newly_q, newly_d, flight_q, flight_d, sspk_q, sspk_d;
  logic [2*W-1:0]     prod_q, prod_d, send_q, send_d;
  logic [W+SegW-1:0]  mulp_q, mulp_d;
  logic               hi_q, hi_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               div_start, div_wide, div_done;
  logic [2*W-1:0]     div_dividend, div_quot, q_ceil;
  logic [W-1:0]       div_divisor, div_rem, seg_w;
  logic               out_free;
  logic [W:0]         dsum, ssum, room, credit, ss_send;
  logic [2*W-1:0]     send_f;
  logic [W+SegW:0]    cw_sum;

  // done pulses for one cycle once the last quotient bit is in
  prrw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .wide_i     (div_wide),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign seg_w    = {{(W-SegW){1'b0}}, seg_size_i};
  assign q_ceil   = div_quot + {{(2*W-1){1'b0}}, (div_rem != '0)};
  assign out_free = !out_valid_q || pop_i;
  assign empty_o  = !out_valid_q;
  assign out_item_o = out_q;

  always_comb begin
    dsum    = {1'b0, deliv_q} + {1'b0, q_ceil[W-1:0]};
    ssum    = {1'b0, sent_q} + {1'b0, q_ceil[W-1:0]};
    room    = {1'b0, sspk_q} - {1'b0, flight_q};
    credit  = (deliv_q > sent_q) ? {1'b0, deliv_q - sent_q} : '0;
    ss_send = (credit > {1'b0, newly_q}) ? credit : {1'b0, newly_q};
    ss_send = ss_send + (W+1)'(item_q.una && !item_q.lost);
    if (ss_send > room) ss_send = room;
    send_f  = (sent_q == '0 && send_q == '0) ? 64'd1 : send_q;
    cw_sum  = {{(SegW+1){1'b0}}, item_q.pipe} + {1'b0, mulp_q};
  end

  always_comb begin
    state_d = state_q;   item_d = item_q;     active_d = active_q;
    deliv_d = deliv_q;   sent_d = sent_q;     prior_d = prior_q;
    newly_d = newly_q;   flight_d = flight_q; sspk_d = sspk_q;
    prod_d  = prod_q;    send_d = send_q;     mulp_d = mulp_q;
    hi_d    = hi_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d   = out_q;
    work_take_o = 1'b0;
    div_start = 1'b0;
    div_wide  = 1'b0;
    div_dividend = {{W{1'b0}}, work_i.amount};
    div_divisor  = seg_w;

    unique case (state_q)
      S_IDLE: begin
        if (work_valid_i && out_free) begin
          work_take_o = 1'b1;
          item_d = work_i;
          out_d.cwnd_out = '0;
          out_d.cwnd_written = 1'b0;
          out_d.recovery_active = active_q;
          unique case (work_i.kind)
            K_RESET: begin
              active_d = 1'b0; deliv_d = '0; sent_d = '0; prior_d = '0;
              out_d.recovery_active = 1'b0;
              out_valid_d = 1'b1;
            end
            K_BEGIN: begin
              div_start = 1'b1; state_d = S_BEGIN_DIV;
            end
            K_SENT: begin
              if (active_q) begin
                div_start = 1'b1; state_d = S_SENT_DIV;
              end else out_valid_d = 1'b1;
            end
            K_ACK: begin
              if (active_q && prior_q != '0) begin
                div_start = 1'b1; state_d = S_ACK_NEW;
              end else out_valid_d = 1'b1;
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      S_BEGIN_DIV: if (div_done) begin
        active_d = 1'b1; deliv_d = '0; sent_d = '0;
        prior_d = (div_quot[W-1:0] == '0) ? W'(1) : div_quot[W-1:0];
        out_d.recovery_active = 1'b1;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_SENT_DIV: if (div_done) begin
        sent_d = ssum[W] ? '1 : ssum[W-1:0];
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_ACK_NEW: if (div_done) begin
        if (q_ceil[W-1:0] == '0) begin
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          newly_d = q_ceil[W-1:0];
          deliv_d = dsum[W] ? '1 : dsum[W-1:0];
          div_start = 1'b1;
          div_dividend = {{W{1'b0}}, item_q.pipe};
          state_d = S_ACK_FLT;
        end
      end
      S_ACK_FLT: if (div_done) begin
        flight_d = q_ceil[W-1:0];
        div_start = 1'b1;
        div_dividend = {{W{1'b0}}, item_q.ssth};
        state_d = S_ACK_SST;
      end
      S_ACK_SST: if (div_done) begin
        sspk_d = (div_quot[W-1:0] == '0) ? W'(1) : div_quot[W-1:0];
        state_d = S_ACK_MUL;
      end
      S_ACK_MUL: begin
        if (sspk_q < flight_q) begin
          prod_d  = sspk_q * deliv_q;
          state_d = S_ACK_TSTART;
        end else begin
          send_d  = {{(W-1){1'b0}}, ss_send};
          state_d = S_ACK_WIN;
        end
      end
      S_ACK_TSTART: begin
        div_start = 1'b1; div_wide = 1'b1;
        div_dividend = prod_q;
        div_divisor  = prior_q;
        state_d = S_ACK_TGT;
      end
      S_ACK_TGT: begin
        div_divisor = prior_q;
        if (div_done) begin
          send_d = (q_ceil > {{W{1'b0}}, sent_q}) ? q_ceil - {{W{1'b0}}, sent_q} : '0;
          state_d = S_ACK_WIN;
        end
      end
      S_ACK_WIN: begin
        hi_d   = (send_f[2*W-1:W] != '0);
        mulp_d = send_f[W-1:0] * seg_size_i;
        state_d = S_ACK_SUM;
      end
      S_ACK_SUM: begin
        out_d.cwnd_out = (hi_q || cw_sum[W+SegW:W] != '0) ? '1 : cw_sum[W-1:0];
        out_d.cwnd_written = 1'b1;
        out_d.recovery_active = active_q;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      deliv_q     <= '0;
      sent_q      <= '0;
      prior_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      deliv_q     <= deliv_d;
      sent_q      <= sent_d;
      prior_q     <= prior_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    newly_q  <= newly_d;
    flight_q <= flight_d;
    sspk_q   <= sspk_d;
    prod_q   <= prod_d;
    send_q   <= send_d;
    mulp_q   <= mulp_d;
    hi_q     <= hi_d;
    out_q    <= out_d;
  end

endmodule
`default_nettype wire

// ===== test/prrw_checker.sv =====
// Checker for the PRR recovery window engine: watches the event and result queues,
// predicts each result from its own copy of the episode state, compares field by field.
// Depends on prrw_pkg.
`timescale 1ns / 1ps
module prrw_checker import prrw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            full_i,
  input  in_item_t        in_item_i,
  input  logic            empty_i,
  input  logic            pop_i,
  input  out_item_t       out_item_i,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [SegW-1:0] cfg_wdata_i,
  output int              fail_cnt_o,
  output int              pending_o
);

  logic [SegW-1:0]  mss_q;
  logic             prr_on_q;
  logic             episode_q;
  logic [WordW-1:0] delivered_q;
  logic [WordW-1:0] sent_q;
  logic [WordW-1:0] prior_q;
  out_item_t        cwnd_updates_q[$];

  assign pending_o = cwnd_updates_q.size();

  function automatic logic [63:0] pkts(logic [63:0] bytes, logic [SegW-1:0] mss);
    if (bytes == 0 || mss == 0) return 0;
    return (bytes + mss - 1) / mss;
  endfunction

  function automatic logic [WordW-1:0] sat_sum(logic [WordW-1:0] a, logic [63:0] b);
    logic [63:0] s;
    s = {32'd0, a} + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // advances the episode state and returns the window update for one event word
  task automatic predict_window(input in_item_t w, output out_item_t r);
    logic [63:0] newly, flight, sspk, send, target, room, credit, win;
    r = '0;
    case (w.cmd)
      CMD_RESET: begin
        episode_q = 0; delivered_q = 0; sent_q = 0; prior_q = 0;
      end
      CMD_BEGIN: begin
        if (prr_on_q && mss_q != 0) begin
          target = w.cwnd_in / mss_q;
          episode_q = 1; delivered_q = 0; sent_q = 0;
          prior_q = (target == 0) ? 1 : target[31:0];
        end
      end
      CMD_SENT: begin
        if (prr_on_q && episode_q && w.in_loss_recovery)
          sent_q = sat_sum(sent_q, pkts(w.byte_count, mss_q));
      end
      default: begin
        newly = pkts(w.byte_count, mss_q);
        if (prr_on_q && episode_q && w.in_loss_recovery && mss_q != 0 &&
            prior_q != 0 && newly != 0) begin
          send = 0;
          delivered_q = sat_sum(delivered_q, newly);
          flight = pkts(w.pipe_bytes, mss_q);
          sspk = w.slow_start_threshold / mss_q;
          if (sspk == 0) sspk = 1;
          if (sspk < flight) begin
            target = (sspk * delivered_q + prior_q - 1) / prior_q;
            if (target > sent_q) send = target - sent_q;
          end else begin
            room = sspk - flight;
            credit = (delivered_q > sent_q) ? delivered_q - sent_q : 0;
            send = (credit > newly) ? credit : newly;
            if (w.una_advanced && !w.any_newly_lost) send++;
            if (send > room) send = room;
          end
          if (sent_q == 0 && send == 0) send = 1;
          win = w.pipe_bytes + send * mss_q;
          r.cwnd_out = (win > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : win[31:0];
          r.cwnd_written = 1;
        end
      end
    endcase
    r.recovery_active = episode_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t p, e;
    if (!rst_ni) begin
      mss_q = SegSizeRst; prr_on_q = PrrEnRst;
      episode_q = 0; delivered_q = 0; sent_q = 0; prior_q = 0;
      cwnd_updates_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (cwnd_updates_q.size() == 0) begin
          $error("unexpected result word %h", out_item_i);
          fail_cnt_o++;
        end else begin
          e = cwnd_updates_q.pop_front();
          if (out_item_i.cwnd_out !== e.cwnd_out) begin
            $error("cwnd_out exp %h got %h", e.cwnd_out, out_item_i.cwnd_out);
            fail_cnt_o++;
          end
          if (out_item_i.cwnd_written !== e.cwnd_written) begin
            $error("cwnd_written exp %b got %b", e.cwnd_written, out_item_i.cwnd_written);
            fail_cnt_o++;
          end
          if (out_item_i.recovery_active !== e.recovery_active) begin
            $error("recovery_active exp %b got %b", e.recovery_active,
                   out_item_i.recovery_active);
            fail_cnt_o++;
          end
        end
      end
      if (push_i && !full_i) begin
        predict_window(in_item_i, p);
        cwnd_updates_q.push_back(p);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SEG_SIZE) mss_q = cfg_wdata_i;
        else prr_on_q = cfg_wdata_i[0];
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the PRR recovery window engine: clock, reset, config phases,
// directed and random event words with random idling; verdict from prrw_checker.
// Depends on prrw_pkg, prr_recovery_window_top, prrw_checker.
`timescale 1ns / 1ps
module tb_top;
  import prrw_pkg::*;

  logic            clk = 0;
  logic            rst_n = 0;
  logic            push = 0;
  logic            full;
  in_item_t        in_item = '0;
  logic            empty;
  logic            pop = 0;
  out_item_t       out_item;
  logic            cfg_we = 0;
  logic            cfg_idx = 0;
  logic [SegW-1:0] cfg_wdata = '0;
  int              fail_cnt;
  int              pending;
  logic            tail_phase = 0;  // no idling near the end
  int              hold_off = 0;    // long receiver stall request

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  prr_recovery_window_top u_top (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_o(full), .in_item_i(in_item),
    .empty_o(empty), .pop_i(pop), .out_item_o(out_item), .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  prrw_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_i(full), .in_item_i(in_item),
    .empty_i(empty), .pop_i(pop), .out_item_i(out_item), .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata), .fail_cnt_o(fail_cnt),
    .pending_o(pending)
  );

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 20000);
      3: return $urandom_range(0, 200000);
      default: return $urandom;
    endcase
  endfunction

  // word with ack-friendly content: moderate sizes so the window math gets exercised
  function automatic in_item_t mk_word(cmd_e c);
    in_item_t w;
    w = '0;
    w.cmd = c;
    w.byte_count = ($urandom_range(0, 9) == 0) ? rnd_word() : $urandom_range(0, 30000);
    w.una_advanced = 1'($urandom_range(0, 1));
    w.any_newly_lost = 1'($urandom_range(0, 1));
    w.pipe_bytes = ($urandom_range(0, 9) == 0) ? rnd_word() : $urandom_range(0, 120000);
    w.slow_start_threshold = ($urandom_range(0, 9) == 0) ? rnd_word()
                                                          : $urandom_range(0, 120000);
    w.cwnd_in = ($urandom_range(0, 9) == 0) ? rnd_word() : $urandom_range(0, 200000);
    w.in_loss_recovery = ($urandom_range(0, 7) != 0);
    return w;
  endfunction

  // push stays high between back-to-back words; it drops only for idling or drain
  task automatic send_word(in_item_t w);
    if (!tail_phase && $urandom_range(0, 5) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_item <= w;
    push <= 1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 0;
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [SegW-1:0] val);
    cfg_idx <= idx;
    cfg_wdata <= val;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        pop <= 0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        pop <= 0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      pop <= 1;
    end
  end

  initial begin
    #50_000_000;
    $display("FAIL prr_recovery_window_top");
    $finish;
  end

  initial begin
    in_item_t w;
    int phase;
    logic [SegW-1:0] mss_set[4];
    mss_set = '{16'd1460, 16'd1, 16'hFFFF, 16'd536};
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: extremes and every event kind
    w = mk_word(CMD_BEGIN); w.cwnd_in = 32'hFFFF_FFFF; send_word(w);
    w = mk_word(CMD_SENT); w.byte_count = 0; send_word(w);
    w = mk_word(CMD_SENT); w.byte_count = 32'hFFFF_FFFF; w.in_loss_recovery = 1;
    send_word(w);
    w = mk_word(CMD_ACK); w.byte_count = 32'hFFFF_FFFF; w.pipe_bytes = 32'hFFFF_FFFF;
    w.slow_start_threshold = 32'hFFFF_FFFF; w.in_loss_recovery = 1; send_word(w);
    w = mk_word(CMD_ACK); w.byte_count = 0; w.in_loss_recovery = 1; send_word(w);
    w = mk_word(CMD_RESET); send_word(w);
    w = mk_word(CMD_ACK); w.in_loss_recovery = 1; w.byte_count = 100; send_word(w);
    w = mk_word(CMD_BEGIN); w.cwnd_in = 0; send_word(w);
    // first send: nothing sent, pipe far above the slow-start threshold
    w = mk_word(CMD_ACK); w.byte_count = 1; w.pipe_bytes = 32'hFFFF_FFFF;
    w.slow_start_threshold = 0; w.in_loss_recovery = 1; send_word(w);
    w = mk_word(CMD_ACK); w.byte_count = 3000; w.pipe_bytes = 0;
    w.slow_start_threshold = 50000; w.una_advanced = 1; w.any_newly_lost = 0;
    w.in_loss_recovery = 1; send_word(w);
    w = mk_word(CMD_BEGIN); w.cwnd_in = 100000; send_word(w);
    w = mk_word(CMD_ACK); w.byte_count = 5000; w.pipe_bytes = 90000;
    w.slow_start_threshold = 20000; w.in_loss_recovery = 1; send_word(w);
    w = mk_word(CMD_ACK); w.in_loss_recovery = 0; send_word(w);
    drain();

    // the sender pauses until all results are back, then the registers change
    for (phase = 0; phase < 8; phase++) begin
      write_reg(REG_SEG_SIZE, (phase == 6) ? 16'd0 : mss_set[phase % 4]);
      write_reg(REG_PRR_EN, (phase == 5) ? 1'b0 : 1'b1);
      if (phase == 2) hold_off = 400;
      if (phase == 7) tail_phase = 1;
      w = mk_word(CMD_BEGIN); send_word(w);
      repeat (55) begin
        case ($urandom_range(0, 19))
          0: w = mk_word(CMD_RESET);
          1, 2: w = mk_word(CMD_BEGIN);
          3, 4, 5, 6: w = mk_word(CMD_SENT);
          default: w = mk_word(CMD_ACK);
        endcase
        if ($urandom_range(0, 15) == 0) begin
          w.byte_count = rnd_word(); w.pipe_bytes = rnd_word();
          w.slow_start_threshold = rnd_word(); w.cwnd_in = rnd_word();
        end
        send_word(w);
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("PASS prr_recovery_window_top");
    end else begin
      $display("FAIL prr_recovery_window_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/prrw_pkg.sv
hdl/prrw_front.sv
hdl/prrw_div.sv
hdl/prrw_back.sv
hdl/prr_recovery_window_top.sv
test/prrw_checker.sv
test/tb_top.sv
